// ----- src/dosc_pkg.sv -----
// Shared types, register indexes and reset values for the dial override slew controller.
// No dependencies; used by every module in src.
package dosc_pkg;

    localparam int DataW     = 8;
    localparam int CfgAddrW  = 3;
    localparam int InTdataW  = 24;
    localparam int InTuserW  = 2;
    localparam int OutTdataW = 24;
    localparam int OutTuserW = 2;

    localparam logic [DataW-1:0] PASSTHROUGH      = 8'h00;
    localparam logic [DataW-1:0] HIGH_RANGE_LEVEL = 8'd128;

    localparam logic [DataW-1:0] RST_OFF_LEVEL     = 8'd5;
    localparam logic [DataW-1:0] RST_MIN_OVERRIDE  = 8'd25;
    localparam logic [DataW-1:0] RST_WAKE_LEVEL    = 8'd230;
    localparam logic [DataW-1:0] RST_SILENCE_LIMIT = 8'd200;
    localparam logic [DataW-1:0] RST_SLEW_STEP     = 8'd3;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_OFF_LEVEL     = 3'd0,
        CFG_MIN_OVERRIDE  = 3'd1,
        CFG_WAKE_LEVEL    = 3'd2,
        CFG_SILENCE_LIMIT = 3'd3,
        CFG_SLEW_STEP     = 3'd4
    } cfg_addr_t;

    typedef struct packed {
        logic [DataW-1:0] off_level;
        logic [DataW-1:0] min_override;
        logic [DataW-1:0] wake_level;
        logic [DataW-1:0] silence_limit;
        logic [DataW-1:0] slew_step;
    } cfg_t;

    typedef struct packed {
        logic [DataW-1:0] adc_sample;
        logic             rx_valid;
        logic             rx_frame_error;
        logic             rx_parity;
        logic [DataW-1:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic [DataW-1:0] dac_value;
        logic             output_enable;
        logic             high_range;
        logic             telemetry_valid;
        logic [DataW-1:0] telemetry_data;
        logic             telemetry_parity;
        logic             command_accepted;
    } out_item_t;

endpackage

// ----- src/dosc_cfg_regs.sv -----
// Configuration register file: five 8-bit settings written through a plain write port.
// Depends on dosc_pkg.
module dosc_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [dosc_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [dosc_pkg::DataW-1:0]     cfg_wdata,
    output dosc_pkg::cfg_t                 cfg
);

    dosc_pkg::cfg_t cfg_reg;
    dosc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (dosc_pkg::cfg_addr_t'(cfg_addr))
                dosc_pkg::CFG_OFF_LEVEL:     cfg_next.off_level     = cfg_wdata;
                dosc_pkg::CFG_MIN_OVERRIDE:  cfg_next.min_override  = cfg_wdata;
                dosc_pkg::CFG_WAKE_LEVEL:    cfg_next.wake_level    = cfg_wdata;
                dosc_pkg::CFG_SILENCE_LIMIT: cfg_next.silence_limit = cfg_wdata;
                dosc_pkg::CFG_SLEW_STEP:     cfg_next.slew_step     = cfg_wdata;
                default: ; // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_level     <= dosc_pkg::RST_OFF_LEVEL;
            cfg_reg.min_override  <= dosc_pkg::RST_MIN_OVERRIDE;
            cfg_reg.wake_level    <= dosc_pkg::RST_WAKE_LEVEL;
            cfg_reg.silence_limit <= dosc_pkg::RST_SILENCE_LIMIT;
            cfg_reg.slew_step     <= dosc_pkg::RST_SLEW_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/dosc_core.sv -----
// Per-tick control: command latch, silence counter, target select and slew limiter.
// Depends on dosc_pkg. State advances on each item that passes to the result register.
module dosc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  dosc_pkg::cfg_t       cfg,
    input  dosc_pkg::in_item_t   item,
    output dosc_pkg::out_item_t  result
);

    logic [dosc_pkg::DataW-1:0] cmd_reg, cmd_next;
    logic [dosc_pkg::DataW-1:0] sil_reg, sil_next;
    logic [dosc_pkg::DataW-1:0] drv_reg, drv_next;

    logic                       accepted;
    logic                       tele;
    logic [dosc_pkg::DataW-1:0] cmd_latched;
    logic [dosc_pkg::DataW-1:0] sil_cur;
    logic [dosc_pkg::DataW-1:0] target;
    logic [dosc_pkg::DataW-1:0] diff;
    logic [dosc_pkg::DataW-1:0] delta;

    always_comb begin
        accepted = item.rx_valid && !item.rx_frame_error
                   && (item.rx_parity == ^item.rx_data);

        cmd_latched = accepted ? item.rx_data : cmd_reg;
        cmd_next    = (item.adc_sample < cfg.off_level) ? dosc_pkg::PASSTHROUGH
                                                        : cmd_latched;
        sil_cur     = accepted ? '0 : sil_reg;

        if (cmd_next == dosc_pkg::PASSTHROUGH) begin
            target = item.adc_sample;
        end else if (sil_cur >= cfg.silence_limit) begin
            target = cfg.off_level;
        end else begin
            target = (cmd_next > cfg.min_override) ? cmd_next : cfg.min_override;
        end

        // move toward target, at most one step
        diff     = (target > drv_reg) ? (target - drv_reg) : (drv_reg - target);
        delta    = (diff < cfg.slew_step) ? diff : cfg.slew_step;
        drv_next = (target > drv_reg) ? (drv_reg + delta) : (drv_reg - delta);

        sil_next = (sil_cur < cfg.silence_limit) ? (sil_cur + 8'd1) : sil_cur;

        tele = accepted || (item.adc_sample > cfg.wake_level);

        result.dac_value        = drv_next;
        result.output_enable    = drv_next >= cfg.off_level;
        result.high_range       = drv_next >= dosc_pkg::HIGH_RANGE_LEVEL;
        result.telemetry_valid  = tele;
        result.telemetry_data   = tele ? item.adc_sample : '0;
        result.telemetry_parity = tele && (^item.adc_sample);
        result.command_accepted = accepted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg <= dosc_pkg::PASSTHROUGH;
            sil_reg <= '0;
            drv_reg <= '0;
        end else if (fire) begin
            cmd_reg <= cmd_next;
            sil_reg <= sil_next;
            drv_reg <= drv_next;
        end
    end

endmodule

// ----- src/dial_override_slew_controller.sv -----
// Dial override slew controller: input register, single-pass tick logic, result register.
// Items pass the input register, then the result register. Throughput: one item per cycle
// unless m_tready stalls, set by the per-item update of drive, command, silence in dosc_core.
// Reset (aresetn low, synchronous): both pipeline registers empty, command passthrough,
// silence count and drive value zero, configuration at its default values.
// Depends on dosc_pkg, dosc_cfg_regs and dosc_core.
module dial_override_slew_controller (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_we,
    input  logic [dosc_pkg::CfgAddrW-1:0]        cfg_addr,
    input  logic [dosc_pkg::DataW-1:0]           cfg_wdata,

    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [7:0] adc_sample, [8] rx_parity, [16:9] rx_data, [23:17] zero
    input  logic [dosc_pkg::InTdataW-1:0]        s_tdata,
    // [0] rx_valid, [1] rx_frame_error
    input  logic [dosc_pkg::InTuserW-1:0]        s_tuser,

    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] dac_value, [8] output_enable, [9] high_range,
    // [17:10] telemetry_data, [18] telemetry_parity, [23:19] zero
    output logic [dosc_pkg::OutTdataW-1:0]       m_tdata,
    // [0] telemetry_valid, [1] command_accepted
    output logic [dosc_pkg::OutTuserW-1:0]       m_tuser
);

    dosc_pkg::cfg_t      cfg;
    dosc_pkg::in_item_t  in_item_reg;
    dosc_pkg::out_item_t result;
    dosc_pkg::out_item_t out_item_reg;

    logic in_vld_reg;
    logic out_vld_reg;
    logic advance;
    logic fire;
    logic take;

    assign advance  = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && advance;
    assign s_tready = !in_vld_reg || advance;
    assign take     = s_tvalid && s_tready;

    dosc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dosc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg.adc_sample     <= s_tdata[7:0];
            in_item_reg.rx_parity      <= s_tdata[8];
            in_item_reg.rx_data        <= s_tdata[16:9];
            in_item_reg.rx_valid       <= s_tuser[0];
            in_item_reg.rx_frame_error <= s_tuser[1];
        end
        if (fire) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0,
                       out_item_reg.telemetry_parity,
                       out_item_reg.telemetry_data,
                       out_item_reg.high_range,
                       out_item_reg.output_enable,
                       out_item_reg.dac_value};
    assign m_tuser  = {out_item_reg.command_accepted, out_item_reg.telemetry_valid};

endmodule

// ----- test/tb.sv -----
// Testbench for dial_override_slew_controller: directed ticks, then random ticks
// under several register settings; results are checked against typed rows or a tick-level predictor.
// Depends on dosc_pkg and the RTL in src.
`timescale 1ns / 100ps

module tb;

    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam dosc_pkg::cfg_addr_t CFG_SPARE = dosc_pkg::cfg_addr_t'(3'd7);

    typedef struct packed {
        dosc_pkg::in_item_t  tick;
        logic                typed;
        dosc_pkg::out_item_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 19;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [dosc_pkg::CfgAddrW-1:0]  cfg_addr  = '0;
    logic [dosc_pkg::DataW-1:0]     cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [dosc_pkg::InTdataW-1:0]  s_tdata   = '0;
    logic [dosc_pkg::InTuserW-1:0]  s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [dosc_pkg::OutTdataW-1:0] m_tdata;
    logic [dosc_pkg::OutTuserW-1:0] m_tuser;

    // predictor copy of registers and state
    dosc_pkg::cfg_t             settings;
    logic [dosc_pkg::DataW-1:0] ovr_cmd;
    logic [dosc_pkg::DataW-1:0] quiet_ticks;
    logic [dosc_pkg::DataW-1:0] drive_lvl;
    logic [dosc_pkg::DataW-1:0] last_adc = '0;

    dosc_pkg::out_item_t tick_results_q[$];
    int                  errors       = 0;
    int                  cycles       = 0;
    int                  src_idle_pct = 0;
    int                  dst_idle_pct = 0;
    logic                row_typed    = 1'b0;
    dosc_pkg::out_item_t row_want     = '0;

    // fields: adc, rx_valid, frame_error, parity, rx_data | typed |
    //         dac, enable, high_range, tele_valid, tele_data, tele_parity, accepted
    dir_row_t directed_rows [DIR_ROWS] = '{
        // dial at zero, nothing moves
        '{'{8'd0, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}},
        // full dial: first slew step, telemetry above wake level
        '{'{8'd255, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b1,
          '{8'd3, 1'b0, 1'b0, 1'b1, 8'd255, 1'b0, 1'b0}},
        // framing error: byte dropped
        '{'{8'd255, 1'b1, 1'b1, 1'b0, 8'hFF}, 1'b1,
          '{8'd6, 1'b1, 1'b0, 1'b1, 8'd255, 1'b0, 1'b0}},
        // bad ninth bit: byte dropped
        '{'{8'd200, 1'b1, 1'b0, 1'b0, 8'h01}, 1'b1,
          '{8'd9, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0}},
        // good command below min_override: target raised to the minimum
        '{'{8'd200, 1'b1, 1'b0, 1'b1, 8'h01}, 1'b1,
          '{8'd12, 1'b1, 1'b0, 1'b1, 8'd200, 1'b1, 1'b1}},
        // good command while dial is off: accepted, then forced to passthrough
        '{'{8'd2, 1'b1, 1'b0, 1'b1, 8'h80}, 1'b1,
          '{8'd9, 1'b1, 1'b0, 1'b1, 8'd2, 1'b1, 1'b1}},
        // rx fields with rx_valid low are ignored; a good byte and threshold dial values follow
        '{'{8'd100, 1'b0, 1'b1, 1'b1, 8'hAA}, 1'b0, '0},
        '{'{8'd100, 1'b1, 1'b0, 1'b0, 8'hFF}, 1'b0, '0},
        '{'{8'd5, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{8'd4, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{8'd231, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{8'd230, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
        // command zero selects passthrough
        '{'{8'd128, 1'b1, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{8'd128, 1'b1, 1'b0, 1'b1, 8'h10}, 1'b0, '0},
        '{'{8'd255, 1'b1, 1'b1, 1'b1, 8'h00}, 1'b0, '0},
        '{'{8'd64, 1'b1, 1'b0, 1'b1, 8'h7F}, 1'b0, '0},
        '{'{8'd255, 1'b1, 1'b0, 1'b1, 8'hFE}, 1'b0, '0},
        '{'{8'd255, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{8'd255, 1'b0, 1'b0, 1'b0, 8'h00}, 1'b0, '0}
    };

    dial_override_slew_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL dial_override_slew_controller");
            $finish;
        end
    end

    // One loop tick of the controller; updates command, silence and drive state.
    function automatic dosc_pkg::out_item_t predict_tick(dosc_pkg::in_item_t t);
        dosc_pkg::out_item_t        r;
        logic [dosc_pkg::DataW-1:0] target;
        logic [dosc_pkg::DataW-1:0] gap;
        logic                       took;
        took = t.rx_valid && !t.rx_frame_error && (t.rx_parity == ^t.rx_data);
        if (took) begin
            ovr_cmd     = t.rx_data;
            quiet_ticks = '0;
        end
        if (t.adc_sample < settings.off_level)
            ovr_cmd = dosc_pkg::PASSTHROUGH;
        if (ovr_cmd == dosc_pkg::PASSTHROUGH)
            target = t.adc_sample;
        else if (quiet_ticks >= settings.silence_limit)
            target = settings.off_level;
        else
            target = (ovr_cmd > settings.min_override) ? ovr_cmd : settings.min_override;
        if (target > drive_lvl) begin
            gap       = target - drive_lvl;
            drive_lvl = drive_lvl + ((gap < settings.slew_step) ? gap : settings.slew_step);
        end else if (target < drive_lvl) begin
            gap       = drive_lvl - target;
            drive_lvl = drive_lvl - ((gap < settings.slew_step) ? gap : settings.slew_step);
        end
        r.dac_value        = drive_lvl;
        r.output_enable    = (drive_lvl >= settings.off_level);
        r.high_range       = (drive_lvl >= dosc_pkg::HIGH_RANGE_LEVEL);
        r.telemetry_valid  = took || (t.adc_sample > settings.wake_level);
        r.telemetry_data   = r.telemetry_valid ? t.adc_sample : '0;
        r.telemetry_parity = r.telemetry_valid ? ^t.adc_sample : 1'b0;
        r.command_accepted = took;
        if (quiet_ticks < settings.silence_limit)
            quiet_ticks = quiet_ticks + 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        dosc_pkg::in_item_t  seen;
        dosc_pkg::out_item_t got;
        dosc_pkg::out_item_t want;
        dosc_pkg::out_item_t pred;
        if (aresetn && s_tvalid && s_tready) begin
            seen.adc_sample     = s_tdata[7:0];
            seen.rx_parity      = s_tdata[8];
            seen.rx_data        = s_tdata[16:9];
            seen.rx_valid       = s_tuser[0];
            seen.rx_frame_error = s_tuser[1];
            pred = predict_tick(seen);
            tick_results_q.push_back(row_typed ? row_want : pred);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.dac_value        = m_tdata[7:0];
            got.output_enable    = m_tdata[8];
            got.high_range       = m_tdata[9];
            got.telemetry_data   = m_tdata[17:10];
            got.telemetry_parity = m_tdata[18];
            got.telemetry_valid  = m_tuser[0];
            got.command_accepted = m_tuser[1];
            if (tick_results_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                want = tick_results_q.pop_front();
                check_field("dac_value", want.dac_value, got.dac_value);
                check_field("output_enable", want.output_enable, got.output_enable);
                check_field("high_range", want.high_range, got.high_range);
                check_field("telemetry_valid", want.telemetry_valid, got.telemetry_valid);
                check_field("telemetry_data", want.telemetry_data, got.telemetry_data);
                check_field("telemetry_parity", want.telemetry_parity, got.telemetry_parity);
                check_field("command_accepted", want.command_accepted, got.command_accepted);
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic drive_tick(input dosc_pkg::in_item_t t, input logic typed,
                              input dosc_pkg::out_item_t want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {7'd0, t.rx_data, t.rx_parity, t.adc_sample};
        s_tuser   <= {t.rx_frame_error, t.rx_valid};
        row_typed <= typed;
        row_want  <= want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tick_results_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(input dosc_pkg::cfg_addr_t a,
                             input logic [dosc_pkg::DataW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        case (a)
            dosc_pkg::CFG_OFF_LEVEL:     settings.off_level     = v;
            dosc_pkg::CFG_MIN_OVERRIDE:  settings.min_override  = v;
            dosc_pkg::CFG_WAKE_LEVEL:    settings.wake_level    = v;
            dosc_pkg::CFG_SILENCE_LIMIT: settings.silence_limit = v;
            dosc_pkg::CFG_SLEW_STEP:     settings.slew_step     = v;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic write_settings(input dosc_pkg::cfg_t c);
        write_reg(dosc_pkg::CFG_OFF_LEVEL, c.off_level);
        write_reg(dosc_pkg::CFG_MIN_OVERRIDE, c.min_override);
        write_reg(dosc_pkg::CFG_WAKE_LEVEL, c.wake_level);
        write_reg(dosc_pkg::CFG_SILENCE_LIMIT, c.silence_limit);
        write_reg(dosc_pkg::CFG_SLEW_STEP, c.slew_step);
        cfg_we <= 1'b0;
    endtask

    // Dial is random, wanders, sits near the thresholds or at an end; about one tick in four
    // carries a byte, most of them good.
    function automatic dosc_pkg::in_item_t next_tick();
        dosc_pkg::in_item_t t;
        int                 a;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: a = $urandom_range(0, 255);
            4, 5, 6:    a = int'(last_adc) + int'($urandom_range(0, 12)) - 6;
            7:          a = int'(settings.off_level) + int'($urandom_range(0, 4)) - 2;
            8:          a = int'(settings.wake_level) + int'($urandom_range(0, 4)) - 2;
            default:    a = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (a < 0) a = 0;
        if (a > 255) a = 255;
        t.adc_sample     = 8'(a);
        last_adc         = t.adc_sample;
        t.rx_data        = ($urandom_range(0, 7) == 0) ? dosc_pkg::PASSTHROUGH
                                                       : 8'($urandom_range(0, 255));
        t.rx_valid       = ($urandom_range(0, 3) == 0);
        t.rx_frame_error = 1'b0;
        t.rx_parity      = ^t.rx_data;
        case ($urandom_range(0, 9))
            0: t.rx_frame_error = 1'b1;
            1: t.rx_parity = ~t.rx_parity;
            2: begin
                t.rx_frame_error = 1'b1;
                t.rx_parity      = ~t.rx_parity;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) begin
            // hold the sender once per run until the pipe is empty
            if (n == count / 2)
                wait_drained();
            drive_tick(next_tick(), 1'b0, '0);
        end
        wait_drained();
    endtask

    initial begin
        dosc_pkg::cfg_t c;
        settings    = '{dosc_pkg::RST_OFF_LEVEL, dosc_pkg::RST_MIN_OVERRIDE,
                        dosc_pkg::RST_WAKE_LEVEL, dosc_pkg::RST_SILENCE_LIMIT,
                        dosc_pkg::RST_SLEW_STEP};
        ovr_cmd     = dosc_pkg::PASSTHROUGH;
        quiet_ticks = '0;
        drive_lvl   = '0;

        src_idle_pct = 9;
        dst_idle_pct = 67;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            drive_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        c = '{8'd20, 8'd60, 8'd180, 8'd6, 8'd7};
        write_settings(c);
        run_random(350);

        src_idle_pct = 67;
        dst_idle_pct = 9;
        c = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1};
        write_settings(c);
        run_random(150);
        c = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd255};
        write_settings(c);
        run_random(150);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        // unmapped index must not disturb any register
        write_reg(CFG_SPARE, 8'hFF);
        // zero silence limit: timeout always holds
        c = '{8'd8, 8'd30, 8'd240, 8'd0, 8'd200};
        write_settings(c);
        run_random(50);
        // zero slew step: drive value frozen
        c = '{8'd8, 8'd30, 8'd240, 8'd20, 8'd0};
        write_settings(c);
        run_random(50);

        for (int p = 0; p < 3; p++) begin
            c.off_level     = 8'($urandom_range(0, 40));
            c.min_override  = 8'($urandom_range(0, 255));
            c.wake_level    = 8'($urandom_range(150, 255));
            c.silence_limit = 8'($urandom_range(1, 30));
            c.slew_step     = 8'($urandom_range(1, 20));
            write_settings(c);
            run_random(100);
        end

        if (errors == 0)
            $display("PASS dial_override_slew_controller");
        else
            $display("FAIL dial_override_slew_controller");
        $finish;
    end

endmodule
